[sv/cra_pkg.sv]
package cra_pkg;

	localparam int CAP_W  = 13;
	localparam int HEAD_W = 12;
	localparam int ADDR_W = 32;
	localparam int CMD_W  = 2;
	localparam int ST_W   = 2;
	localparam int ARITH_W = CAP_W + 1;
	localparam int CNT_W  = $clog2(CAP_W);

	localparam logic [CAP_W-1:0] MAX_CAPACITY = 13'd4096;
	localparam logic [CNT_W-1:0] MOD_FIRST_BIT = CNT_W'(CAP_W - 1);

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	localparam logic [0:0] REG_CAPACITY = 1'b0;
	localparam logic [0:0] REG_BASE     = 1'b1;

	typedef struct packed {
		logic commit;
		logic use_rem;
		logic load_mod;
		logic step_mod;
	} ctrl_cmd_t;

	typedef struct packed {
		logic needs_mod;
		logic mod_last;
	} dp_stat_t;

endpackage

[sv/contiguous_ring_allocator.sv]
// Free, peek, most allocations: result is registered in the cycle after input transfer.
// An allocation whose tail offset reaches twice the capacity (only after the
// capacity shrinks) runs a bit-serial remainder and takes no new input meanwhile.
// Throughput: one item per cycle on the fast path while m_axis_tready is high.
// Reset (arst_n low, asynchronous): ring empty, capacity 4096, base 0, no result held.
module contiguous_ring_allocator import cra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [12:0] byte_len, [15:13] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [31:0] item_address, [44:32] used_bytes, [47:45] zero
	output logic [1:0]  m_axis_tuser   // [1:0] status
);

	ctrl_cmd_t         ctrl;
	dp_stat_t          stat;
	logic [ADDR_W-1:0] address;
	logic [CAP_W-1:0]  used;

	cra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.ctrl      (ctrl),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid)
	);

	cra_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_command  (s_axis_tuser),
		.in_size     (s_axis_tdata[CAP_W-1:0]),
		.ctrl        (ctrl),
		.stat        (stat),
		.out_status  (m_axis_tuser),
		.out_address (address),
		.out_used    (used)
	);

	assign m_axis_tdata = {3'b000, used, address};

`ifndef SYNTHESIS
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |=> m_axis_tvalid)
		else $error("result not presented after commit");

	a_slow_path_clears_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_mod |=> !m_axis_tvalid)
		else $error("result still held while remainder runs");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step_mod || ctrl.use_rem) |-> !s_axis_tready)
		else $error("input ready while allocation in progress");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[44:32] <= MAX_CAPACITY))
		else $error("used bytes above capacity");
`endif

endmodule

[sv/cra_dp.sv]
module cra_dp import cra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [0:0]        cfg_index,
	input  logic [31:0]       cfg_wdata,
	input  logic [CMD_W-1:0]  in_command,
	input  logic [CAP_W-1:0]  in_size,
	input  ctrl_cmd_t         ctrl,
	output dp_stat_t          stat,
	output logic [ST_W-1:0]   out_status,
	output logic [ADDR_W-1:0] out_address,
	output logic [CAP_W-1:0]  out_used
);

	logic [CAP_W-1:0]   cap_reg_q;
	logic [ADDR_W-1:0]  base_q;
	logic [HEAD_W-1:0]  head_q;
	logic [CAP_W-1:0]   used_q;
	logic [HEAD_W-1:0]  pad_q;
	logic [CAP_W-1:0]   n_q;
	logic [CAP_W-1:0]   tail_q;
	logic [ARITH_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ST_W-1:0]    status_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [CAP_W-1:0]   used_out_q;

	logic [CAP_W-1:0]   cap;
	logic [ARITH_W-1:0] cap14;
	logic [ARITH_W-1:0] tail_w;
	logic [ARITH_W-1:0] loc_fast;
	logic [ARITH_W-1:0] rem_sh;
	logic [ARITH_W-1:0] rem_nx;

	logic [CMD_W-1:0]   cmd_e;
	logic [CAP_W-1:0]   n_e;
	logic [ARITH_W-1:0] loc_e;

	logic [ST_W-1:0]    st_n;
	logic [ADDR_W-1:0]  addr_n;
	logic [HEAD_W-1:0]  head_n;
	logic [CAP_W-1:0]   used_n;
	logic [HEAD_W-1:0]  pad_n;

	always_comb begin
		if (cap_reg_q == '0) begin
			cap = CAP_W'(1);
		end else if (cap_reg_q > MAX_CAPACITY) begin
			cap = MAX_CAPACITY;
		end else begin
			cap = cap_reg_q;
		end
	end

	assign cap14    = {1'b0, cap};
	assign tail_w   = {2'b00, head_q} + {1'b0, used_q};
	assign loc_fast = (tail_w < cap14) ? tail_w : tail_w - cap14;

	assign stat.needs_mod = (in_command == CMD_ALLOC) && (tail_w >= {cap, 1'b0});
	assign stat.mod_last  = (cnt_q == '0);

	// one remainder bit per cycle, MSB first
	assign rem_sh = {rem_q[ARITH_W-2:0], tail_q[cnt_q]};
	assign rem_nx = (rem_sh >= cap14) ? rem_sh - cap14 : rem_sh;

	assign cmd_e = ctrl.use_rem ? CMD_ALLOC : in_command;
	assign n_e   = ctrl.use_rem ? n_q : in_size;
	assign loc_e = ctrl.use_rem ? rem_q : loc_fast;

	always_comb begin
		logic [ARITH_W-1:0] n14;
		logic [ARITH_W-1:0] used14;
		logic [ARITH_W-1:0] head14;
		logic [ARITH_W-1:0] pad14;
		logic [ARITH_W-1:0] h_w;
		logic [ARITH_W-1:0] u_w;
		logic [ARITH_W-1:0] p_w;
		logic               avail;
		n14    = {1'b0, n_e};
		used14 = {1'b0, used_q};
		head14 = {2'b00, head_q};
		pad14  = {2'b00, pad_q};
		h_w    = head14;
		u_w    = used14;
		p_w    = pad14;
		avail  = 1'b0;
		st_n   = ST_OK;
		addr_n = '0;
		head_n = head_q;
		used_n = used_q;
		pad_n  = pad_q;
		unique case (cmd_e)
			CMD_ALLOC: begin
				if (used14 + n14 > cap14) begin
					st_n = ST_FULL;
				end else if (loc_e + n14 > cap14) begin
					if (tail_w > cap14 || n14 > head14) begin
						st_n = ST_FULL;
					end else begin
						p_w    = cap14 - tail_w;
						u_w    = used14 + p_w + n14;
						pad_n  = p_w[HEAD_W-1:0];
						used_n = u_w[CAP_W-1:0];
						addr_n = base_q;
					end
				end else begin
					u_w    = used14 + n14;
					used_n = u_w[CAP_W-1:0];
					addr_n = base_q + {{(ADDR_W-ARITH_W){1'b0}}, loc_e};
				end
			end
			CMD_FREE, CMD_PEEK: begin
				avail = (n_e == '0) ||
				        ((used14 >= n14) && (head14 + n14 + pad14 <= cap14));
				if (!avail) begin
					st_n = ST_EMPTY;
				end else begin
					addr_n = base_q + {{(ADDR_W-HEAD_W){1'b0}}, head_q};
					if (cmd_e == CMD_FREE) begin
						h_w = head14 + n14;
						u_w = (used14 >= n14) ? used14 - n14 : '0;
						if (h_w + p_w >= cap14) begin
							h_w = '0;
							u_w = (u_w >= p_w) ? u_w - p_w : '0;
							p_w = '0;
						end
						if (u_w == '0) begin
							h_w = '0;
							p_w = '0;
						end
						head_n = h_w[HEAD_W-1:0];
						used_n = u_w[CAP_W-1:0];
						pad_n  = p_w[HEAD_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_reg_q <= MAX_CAPACITY;
			base_q    <= '0;
			head_q    <= '0;
			used_q    <= '0;
			pad_q     <= '0;
			cnt_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_CAPACITY: cap_reg_q <= cfg_wdata[CAP_W-1:0];
					REG_BASE:     base_q    <= cfg_wdata;
				endcase
			end
			if (ctrl.commit) begin
				head_q <= head_n;
				used_q <= used_n;
				pad_q  <= pad_n;
			end
			if (ctrl.load_mod) begin
				cnt_q <= MOD_FIRST_BIT;
			end else if (ctrl.step_mod) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_mod) begin
			tail_q <= tail_w[CAP_W-1:0];
			n_q    <= in_size;
			rem_q  <= '0;
		end else if (ctrl.step_mod) begin
			rem_q <= rem_nx;
		end
		if (ctrl.commit) begin
			status_q   <= st_n;
			addr_q     <= addr_n;
			used_out_q <= used_n;
		end
	end

	assign out_status  = status_q;
	assign out_address = addr_q;
	assign out_used    = used_out_q;

endmodule

[sv/cra_ctrl.sv]
module cra_ctrl import cra_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t ctrl,
	output logic      in_ready,
	output logic      out_valid
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOD  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       out_valid_q;
	logic       accept;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_n = state_q;
		ctrl    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (stat.needs_mod) begin
						ctrl.load_mod = 1'b1;
						state_n       = S_MOD;
					end else begin
						ctrl.commit = 1'b1;
					end
				end
			end
			S_MOD: begin
				ctrl.step_mod = 1'b1;
				if (stat.mod_last) begin
					state_n = S_FIN;
				end
			end
			S_FIN: begin
				ctrl.commit  = 1'b1;
				ctrl.use_rem = 1'b1;
				state_n      = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctrl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
